// ===== hw/rtl/at_response_line_parser_unit_macros.svh =====
// Assertion macros shared by the parser checker.
`ifndef AT_RESPONSE_LINE_PARSER_UNIT_MACROS_SVH
`define AT_RESPONSE_LINE_PARSER_UNIT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ARLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle brings another in the next cycle.
`define ARLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/arlp_pkg.sv =====
// Types, codes and response patterns for the modem line parser.
package arlp_pkg;

	// Event codes of one result item
	typedef enum logic [3:0] {
		EV_NONE      = 4'd0,
		EV_READY     = 4'd1,
		EV_RESTART   = 4'd2,
		EV_CONNECT   = 4'd3,
		EV_CLOSED    = 4'd4,
		EV_OK        = 4'd5,
		EV_ERROR     = 4'd6,
		EV_PAYLOAD   = 4'd7,
		EV_EMPTY     = 4'd8,
		EV_UNKNOWN   = 4'd9
	} ev_t;

	// Parser modes
	typedef enum logic [1:0] {
		MODE_LINE    = 2'd0,
		MODE_HEADER  = 2'd1,
		MODE_PAYLOAD = 2'd2
	} mode_t;

	// Result of one step, from the core to the output register
	typedef struct packed {
		ev_t        code;
		logic [7:0] data;
		logic       last;
		logic [7:0] link_id;
		logic       link_up;
	} res_t;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	// Pattern table: text left aligned, first character in the top byte
	localparam int NPAT      = 10;
	localparam int PAT_CHARS = 10;
	localparam int PAT_W     = 8 * PAT_CHARS;

	localparam int P_IPD     = 0;
	localparam int P_PROMPT  = 1;
	localparam int P_READY   = 2;
	localparam int P_OK      = 3;
	localparam int P_ERROR   = 4;
	localparam int P_SENDOK  = 5;
	localparam int P_CONNECT = 6;
	localparam int P_CLOSED  = 7;
	localparam int P_BLANK   = 8;
	localparam int P_RECV    = 9;

	localparam logic [PAT_W-1:0] PAT_TEXT [NPAT] = '{
		{"+IPD", 48'd0},
		{"> ", 64'd0},
		{"ready", CH_CR, CH_LF, 24'd0},
		{"OK", CH_CR, CH_LF, 48'd0},
		{"ERROR", CH_CR, CH_LF, 24'd0},
		{"SEND OK", CH_CR, CH_LF, 8'd0},
		{",CONNECT", CH_CR, CH_LF},
		{",CLOSED", CH_CR, CH_LF, 8'd0},
		{CH_CR, CH_LF, 64'd0},
		{"Recv", 48'd0}
	};
	localparam logic [3:0] PAT_LEN [NPAT] = '{
		4'd4, 4'd2, 4'd7, 4'd4, 4'd7, 4'd9, 4'd10, 4'd9, 4'd2, 4'd4
	};
	localparam logic [3:0] PAT_OFS [NPAT] = '{
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd0, 4'd0
	};
	localparam logic [NPAT-1:0] PAT_EXACT = 10'b0111111100;

	// Pick character i of a pattern text
	function automatic logic [7:0] pat_char(input logic [PAT_W-1:0] t, input logic [3:0] i);
		pat_char = t[PAT_W - 1 - 8 * i -: 8];
	endfunction

endpackage

// ===== hw/rtl/arlp_core.sv =====
// Parser state and per-byte next-state logic of the modem line parser.
module arlp_core #(
	parameter int MAX_PAYLOAD = 2048,
	parameter int MAX_LINE    = 255
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     rx_char,
	input  logic           report_unknown,
	output arlp_pkg::res_t res
);
	import arlp_pkg::*;

	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int POS_W = $clog2(MAX_LINE + 1);
	localparam int ACC_W = LEN_W + 4;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE);

	mode_t             mode_q, mode_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic [NPAT-1:0]   cand_q, cand_n;
	logic [7:0]        first_q, first_n;
	logic              comma_q, comma_n;
	logic [1:0]        hcommas_q, hcommas_n;
	logic [LEN_W-1:0]  len_q, len_n;
	logic [LEN_W-1:0]  rem_q, rem_n;
	logic              ready_q, ready_n;
	logic [7:0]        link_id_q, link_id_n;
	logic              link_up_q, link_up_n;

	// shared decode
	logic [NPAT-1:0]   cand_upd;
	logic [7:0]        first_upd;
	logic              comma_upd;
	logic              ipd_hit, prompt_hit, is_lf, is_digit, do_step;
	ev_t               line_ev;
	logic [ACC_W-1:0]  acc_x10;
	logic [LEN_W-1:0]  acc_sat;

	// Match the byte against every live pattern and classify the line
	always_comb begin
		logic [POS_W-1:0] q;
		q         = '0;
		cand_upd  = cand_q;
		for (int k = 0; k < NPAT; k++) begin
			if (pos_q >= POS_W'(PAT_OFS[k])) begin
				q = pos_q - POS_W'(PAT_OFS[k]);
				if (q < POS_W'(PAT_LEN[k])) begin
					if (pat_char(PAT_TEXT[k], q[3:0]) != rx_char)
						cand_upd[k] = 1'b0;
				end else if (PAT_EXACT[k]) begin
					cand_upd[k] = 1'b0;
				end
			end
		end
		first_upd = (pos_q == '0) ? rx_char : first_q;
		comma_upd = comma_q | ((pos_q != '0) && (rx_char == CH_COMMA));
		ipd_hit    = (pos_q == POS_W'(3)) && cand_upd[P_IPD];
		prompt_hit = (pos_q == POS_W'(1)) && cand_upd[P_PROMPT];
		is_lf      = (rx_char == CH_LF);
		is_digit   = rx_char inside {[CH_0:CH_9]};
		do_step    = step && (rx_char != CH_NUL);

		if (cand_upd[P_READY])
			line_ev = ready_q ? EV_RESTART : EV_READY;
		else if (cand_upd[P_CONNECT])
			line_ev = EV_CONNECT;
		else if (cand_upd[P_CLOSED])
			line_ev = EV_CLOSED;
		else if (cand_upd[P_ERROR])
			line_ev = EV_ERROR;
		else if (cand_upd[P_OK] || cand_upd[P_SENDOK])
			line_ev = EV_OK;
		else if (cand_upd[P_BLANK] || cand_upd[P_RECV])
			line_ev = EV_NONE;
		else if (comma_upd && (first_upd != CH_COMMA))
			line_ev = EV_NONE;
		else if (report_unknown)
			line_ev = EV_UNKNOWN;
		else
			line_ev = EV_NONE;

		// length times ten plus the digit, saturated
		acc_x10 = ({4'd0, len_q} << 3) + ({4'd0, len_q} << 1) + ACC_W'(rx_char[3:0]);
		acc_sat = (acc_x10 > ACC_W'(MAX_PAYLOAD)) ? LEN_MAX : acc_x10[LEN_W-1:0];
	end

	// Next state
	always_comb begin
		mode_n    = mode_q;
		pos_n     = pos_q;
		cand_n    = cand_q;
		first_n   = first_q;
		comma_n   = comma_q;
		hcommas_n = hcommas_q;
		len_n     = len_q;
		rem_n     = rem_q;
		ready_n   = ready_q;
		link_id_n = link_id_q;
		link_up_n = link_up_q;
		if (do_step) begin
			case (mode_q)
				MODE_PAYLOAD: begin
					if (rem_q <= LEN_W'(1)) begin
						rem_n   = '0;
						mode_n  = MODE_LINE;
						pos_n   = '0;
						cand_n  = '1;
						first_n = '0;
						comma_n = 1'b0;
					end else begin
						rem_n = rem_q - LEN_W'(1);
					end
				end
				MODE_HEADER: begin
					if (rx_char == CH_COLON) begin
						len_n = '0;
						if (len_q == '0) begin
							mode_n  = MODE_LINE;
							pos_n   = '0;
							cand_n  = '1;
							first_n = '0;
							comma_n = 1'b0;
						end else begin
							rem_n  = (len_q > LEN_MAX) ? LEN_MAX : len_q;
							mode_n = MODE_PAYLOAD;
						end
					end else if (hcommas_q == 2'd2) begin
						if (is_digit)
							len_n = acc_sat;
						else
							hcommas_n = 2'd3;
					end else if ((rx_char == CH_COMMA) && (hcommas_q < 2'd2)) begin
						hcommas_n = hcommas_q + 2'd1;
					end
				end
				MODE_LINE: begin
					cand_n  = cand_upd;
					first_n = first_upd;
					comma_n = comma_upd;
					if (ipd_hit) begin
						mode_n    = MODE_HEADER;
						hcommas_n = '0;
						len_n     = '0;
					end else if (prompt_hit || is_lf) begin
						pos_n   = '0;
						cand_n  = '1;
						first_n = '0;
						comma_n = 1'b0;
						if (!prompt_hit) begin
							case (line_ev)
								EV_READY, EV_RESTART: ready_n = 1'b1;
								EV_CONNECT: begin
									link_id_n = first_upd;
									link_up_n = 1'b1;
								end
								EV_CLOSED: begin
									link_id_n = '0;
									link_up_n = 1'b0;
								end
								default: ;
							endcase
						end
					end else if (pos_q < POS_MAX) begin
						pos_n = pos_q + POS_W'(1);
					end
				end
				default: mode_n = MODE_LINE;
			endcase
		end
	end

	// Result of this byte
	always_comb begin
		res.code    = EV_NONE;
		res.data    = '0;
		res.last    = 1'b0;
		res.link_id = link_id_n;
		res.link_up = link_up_n;
		if (do_step) begin
			case (mode_q)
				MODE_PAYLOAD: begin
					res.code = EV_PAYLOAD;
					res.data = rx_char;
					res.last = (rem_q <= LEN_W'(1));
				end
				MODE_HEADER: begin
					if ((rx_char == CH_COLON) && (len_q == '0))
						res.code = EV_EMPTY;
				end
				MODE_LINE: begin
					if (ipd_hit)
						res.code = EV_NONE;
					else if (prompt_hit)
						res.code = EV_OK;
					else if (is_lf)
						res.code = line_ev;
				end
				default: res.code = EV_NONE;
			endcase
		end
	end

	// Hold the parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_LINE;
			pos_q     <= '0;
			cand_q    <= '1;
			first_q   <= '0;
			comma_q   <= 1'b0;
			hcommas_q <= '0;
			len_q     <= '0;
			rem_q     <= '0;
			ready_q   <= 1'b0;
			link_id_q <= '0;
			link_up_q <= 1'b0;
		end else if (step) begin
			mode_q    <= mode_n;
			pos_q     <= pos_n;
			cand_q    <= cand_n;
			first_q   <= first_n;
			comma_q   <= comma_n;
			hcommas_q <= hcommas_n;
			len_q     <= len_n;
			rem_q     <= rem_n;
			ready_q   <= ready_n;
			link_id_q <= link_id_n;
			link_up_q <= link_up_n;
		end
	end

endmodule

// ===== hw/rtl/at_response_line_parser_unit.sv =====
// Modem response line parser: byte in, one event item out per byte.
//
// Input channel in_valid/in_ready carries one received byte (rx_byte) per
// item; zero bytes are taken and give an item with event none. Output
// channel out_valid/out_ready carries one item per input byte: event_res,
// the link status after the byte (link_char, link_open) and, for payload
// events, payload_data and payload_last.
// A byte is held in an input register, parsed by single-level logic, and
// its item lands in the output register; one item per cycle is sustained
// while out_ready stays high.
// When the receiver stalls, the output register holds its item and the
// input register takes one more byte; after that in_ready drops until the
// output item is taken.
// cfg_we writes report_q from cfg_wdata in the same cycle;
// write it only while no item is in flight.
// Reset empties both registers and returns the parser to the start of a
// line with no link and the modem not yet ready.
module at_response_line_parser_unit #(
	parameter int MAX_PAYLOAD = 2048,
	parameter int MAX_LINE    = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] event_res,
	output logic [7:0] link_char,
	output logic       link_open,
	output logic [7:0] payload_data,
	output logic       payload_last
);
	import arlp_pkg::*;

	logic       vld_s1;
	logic [7:0] rx_s1;
	logic       advance;
	logic       report_q;
	res_t       res;
	res_t       res_s2;
	logic       vld_s2;

	assign advance  = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || advance;

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			report_q <= 1'b0;
		else if (cfg_we)
			report_q <= cfg_wdata;
	end

	// Capture the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_ready)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			rx_s1 <= rx_byte;
	end

	arlp_core #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.MAX_LINE    (MAX_LINE)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.rx_char        (rx_s1),
		.report_unknown (report_q),
		.res            (res)
	);

	// Advance the result into the output register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (advance)
			vld_s2 <= 1'b1;
		else if (out_ready)
			vld_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res;
	end

	assign out_valid    = vld_s2;
	assign event_res    = res_s2.code;
	assign link_char    = res_s2.link_id;
	assign link_open    = res_s2.link_up;
	assign payload_data = res_s2.data;
	assign payload_last = res_s2.last;

endmodule

// ===== hw/rtl/arlp_checker.sv =====
// Port-level assertions for the modem line parser, bound to the top level.
`include "at_response_line_parser_unit_macros.svh"

module arlp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] event_res,
	input logic       link_open,
	input logic [7:0] payload_data,
	input logic       payload_last
);
	import arlp_pkg::*;

	`ARLP_ASSERT(a_last_is_payload, !(out_valid && payload_last) || (event_res == EV_PAYLOAD), "payload_last on a non-payload item")
	`ARLP_ASSERT(a_data_zero, !(out_valid && (event_res != EV_PAYLOAD)) || (payload_data == 8'd0), "payload_data set outside a payload item")
	`ARLP_ASSERT(a_connect_up, !(out_valid && (event_res == EV_CONNECT)) || link_open, "connect item without an open link")
	`ARLP_ASSERT(a_closed_down, !(out_valid && (event_res == EV_CLOSED)) || !link_open, "closed item with the link still open")
	`ARLP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(event_res), "stalled item changed")

endmodule

bind at_response_line_parser_unit arlp_checker u_arlp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.event_res    (event_res),
	.link_open    (link_open),
	.payload_data (payload_data),
	.payload_last (payload_last)
);
